// File: hdl/sfr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sfr_pkg
// Shared constants, codes and types of the sensor frame receiver.
// ----------------------------------------------------------------------------
package sfr_pkg;

  // frame bytes
  localparam logic [7:0] StartByte = 8'h68;
  localparam logic [7:0] MarkByte  = 8'h80;
  localparam logic [7:0] EndByte   = 8'h16;

  // payload bytes kept per frame, and bytes the report is built from
  localparam int unsigned PayloadBytes = 24;
  localparam int unsigned FieldBytes   = 24;
  localparam int unsigned PayloadIdxW  = $clog2(PayloadBytes);

  // channels that take part in matching and timing, and channel registers
  localparam int unsigned Channels    = 4;
  localparam int unsigned NumChanRegs = 4;

  localparam logic [15:0] LimitReset = 16'd6000;
  localparam logic [15:0] CountMax   = 16'hFFFF;
  localparam logic [2:0]  NoChannel  = 3'd4;

  typedef enum logic [2:0] {
    CfgChannelEnable = 3'd0,
    CfgChannelId0    = 3'd1,
    CfgChannelId1    = 3'd2,
    CfgChannelId2    = 3'd3,
    CfgChannelId3    = 3'd4,
    CfgSilenceLimit  = 3'd5
  } cfg_reg_e;

  typedef enum logic {
    OpByte = 1'b0,
    OpTick = 1'b1
  } op_e;

  typedef enum logic {
    KindFrame = 1'b0,
    KindTick  = 1'b1
  } kind_e;

  // completed frame as seen by the channel logic
  typedef struct packed {
    logic                       done;
    logic [7:0]                 id;
    logic [FieldBytes-1:0][7:0] data;
  } frame_t;

  typedef struct packed {
    logic        kind;
    logic [2:0]  matched_channel;
    logic [7:0]  sensor_id;
    logic [7:0]  status;
    logic [23:0] frame_number;
    logic [31:0] battery;
    logic [31:0] oxygen;
    logic [31:0] carbon_monoxide;
    logic [31:0] hydrogen_sulfide;
    logic [31:0] explosive_gas;
    logic [4:0]  alarm_mask;
    logic [3:0]  timeout_mask;
  } result_t;

endpackage
`default_nettype wire

// File: hdl/sfr_parser.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sfr_parser
// Byte-level frame parser: start, id, mark, length, data, checksum, end.
// ----------------------------------------------------------------------------
module sfr_parser (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           byte_valid_i,
  input  wire logic [7:0]     byte_i,
  output sfr_pkg::frame_t     frame_o
);

  typedef enum logic [2:0] {
    PhHunt = 3'd0,
    PhId   = 3'd1,
    PhMark = 3'd2,
    PhLen  = 3'd3,
    PhData = 3'd4,
    PhSum  = 3'd5,
    PhEnd  = 3'd6
  } phase_e;

  phase_e     phase_q;
  logic [7:0] id_q;
  logic [7:0] len_q;
  logic [7:0] count_q;
  logic [7:0] sum_q;
  logic [7:0] store_q [sfr_pkg::PayloadBytes];

  logic [7:0] count_inc;
  phase_e     resync_phase;

  assign count_inc    = count_q + 8'd1;
  assign resync_phase = (byte_i == sfr_pkg::StartByte) ? PhId : PhHunt;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhHunt;
      id_q    <= '0;
      len_q   <= '0;
      count_q <= '0;
      sum_q   <= '0;
    end else if (byte_valid_i) begin
      unique case (phase_q)
        PhHunt: phase_q <= resync_phase;
        PhId: begin
          id_q    <= byte_i;
          phase_q <= PhMark;
        end
        PhMark: phase_q <= (byte_i == sfr_pkg::MarkByte) ? PhLen : resync_phase;
        PhLen: begin
          len_q   <= byte_i;
          count_q <= '0;
          sum_q   <= '0;
          phase_q <= (byte_i == 8'd0) ? PhSum : PhData;
        end
        PhData: begin
          sum_q   <= sum_q + byte_i;
          count_q <= count_inc;
          if (count_inc == len_q) begin
            phase_q <= PhSum;
          end
        end
        PhSum: phase_q <= (byte_i == sum_q) ? PhEnd : resync_phase;
        // a good end byte is never a start byte, so resync covers both
        PhEnd: phase_q <= resync_phase;
        default: phase_q <= PhHunt;
      endcase
    end
  end

  // bytes past the payload store still count toward the checksum
  always_ff @(posedge clk_i) begin
    if (byte_valid_i && (phase_q == PhData) &&
        (count_q < 8'(sfr_pkg::PayloadBytes))) begin
      store_q[count_q[sfr_pkg::PayloadIdxW-1:0]] <= byte_i;
    end
  end

  always_comb begin
    frame_o.done = byte_valid_i && (phase_q == PhEnd) && (byte_i == sfr_pkg::EndByte);
    frame_o.id   = id_q;
    for (int k = 0; k < sfr_pkg::FieldBytes; k++) begin
      // bytes beyond the declared length read as zero
      frame_o.data[k] = (8'(k) < len_q) ? store_q[k] : 8'd0;
    end
  end

endmodule
`default_nettype wire

// File: hdl/sensor_frame_receiver.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sensor_frame_receiver
// Sensor frame parser with channel matching, alarms and silence timers.
// ----------------------------------------------------------------------------
// Takes one beat per clock unless stalled: a received byte or a time tick.
// Parser state, channel alarms and silence counters are all updated in the
// cycle the beat is accepted, so the sustained rate is one beat per cycle
// while reports are taken. A closing end byte of a valid frame yields a frame
// report, a tick yields a timeout report, and other bytes yield nothing.
// Reports are registered into a two-entry output buffer as their beat is
// accepted; the input stalls only while both hold reports not yet taken.
// The user must write configuration only while the block is idle; unchecked.
module sensor_frame_receiver (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [2:0]  cfg_index_i,
  input  wire logic [15:0] cfg_data_i,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic        operation_i,
  input  wire logic [7:0]  rx_byte_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic             result_kind_o,
  output logic [2:0]       matched_channel_o,
  output logic [7:0]       frame_sensor_id_o,
  output logic [7:0]       frame_status_o,
  output logic [23:0]      frame_number_o,
  output logic [31:0]      battery_bits_o,
  output logic [31:0]      oxygen_bits_o,
  output logic [31:0]      carbon_monoxide_bits_o,
  output logic [31:0]      hydrogen_sulfide_bits_o,
  output logic [31:0]      explosive_gas_bits_o,
  output logic [4:0]       alarm_mask_o,
  output logic [3:0]       timeout_mask_o
);

  // configuration
  logic [3:0]  enable_q;
  logic [15:0] chan_id_q [sfr_pkg::NumChanRegs];
  logic [15:0] limit_q;

  // channel state
  logic [3:0]  alarm_q, alarm_d;
  logic [15:0] silence_q [sfr_pkg::NumChanRegs];
  logic [15:0] silence_d [sfr_pkg::NumChanRegs];

  // output buffer
  sfr_pkg::result_t buf_q [2];
  logic             wr_ptr_q, rd_ptr_q;
  logic [1:0]       count_q;

  logic             in_accept;
  logic             is_tick;
  logic             push, pop;
  sfr_pkg::frame_t  frame;
  sfr_pkg::result_t result;
  logic [2:0]       hit;
  logic [3:0]       flags;
  logic [15:0]      inc;

  assign in_stall_o = (count_q == 2'd2);
  assign in_accept  = in_valid_i && !in_stall_o;
  assign is_tick    = (operation_i == sfr_pkg::OpTick);

  sfr_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .byte_valid_i(in_accept && !is_tick),
    .byte_i      (rx_byte_i),
    .frame_o     (frame)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q <= '0;
      limit_q  <= sfr_pkg::LimitReset;
      for (int n = 0; n < sfr_pkg::NumChanRegs; n++) begin
        chan_id_q[n] <= '0;
      end
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        sfr_pkg::CfgChannelEnable: enable_q     <= cfg_data_i[3:0];
        sfr_pkg::CfgChannelId0:    chan_id_q[0] <= cfg_data_i;
        sfr_pkg::CfgChannelId1:    chan_id_q[1] <= cfg_data_i;
        sfr_pkg::CfgChannelId2:    chan_id_q[2] <= cfg_data_i;
        sfr_pkg::CfgChannelId3:    chan_id_q[3] <= cfg_data_i;
        sfr_pkg::CfgSilenceLimit:  limit_q      <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // first enabled channel whose id equals the frame id wins
  always_comb begin
    hit = sfr_pkg::NoChannel;
    for (int n = sfr_pkg::Channels - 1; n >= 0; n--) begin
      if (enable_q[n] && (chan_id_q[n] == {8'd0, frame.id})) begin
        hit = 3'(n);
      end
    end
  end

  always_comb begin
    alarm_d = alarm_q;
    flags   = '0;
    inc     = '0;
    for (int n = 0; n < sfr_pkg::NumChanRegs; n++) begin
      silence_d[n] = silence_q[n];
    end
    if (in_accept && is_tick) begin
      for (int n = 0; n < sfr_pkg::Channels; n++) begin
        inc = (silence_q[n] != sfr_pkg::CountMax) ? silence_q[n] + 16'd1 : silence_q[n];
        silence_d[n] = inc;
        if (inc >= limit_q) begin
          if (enable_q[n]) begin
            silence_d[n] = limit_q;
            flags[n]     = 1'b1;
          end else begin
            silence_d[n] = '0;
          end
        end
      end
    end else if (frame.done && (hit != sfr_pkg::NoChannel)) begin
      alarm_d[hit[1:0]]   = (frame.data[0] == 8'd1);
      silence_d[hit[1:0]] = '0;
    end
  end

  always_comb begin
    result = '0;
    if (is_tick) begin
      result.kind         = sfr_pkg::KindTick;
      result.timeout_mask = flags;
    end else begin
      result.kind             = sfr_pkg::KindFrame;
      result.matched_channel  = hit;
      result.sensor_id        = frame.id;
      result.status           = frame.data[0];
      result.frame_number     = frame.data[3:1];
      result.battery          = frame.data[7:4];
      result.oxygen           = frame.data[11:8];
      result.carbon_monoxide  = frame.data[15:12];
      result.hydrogen_sulfide = frame.data[19:16];
      result.explosive_gas    = frame.data[23:20];
      result.alarm_mask       = {|alarm_d, alarm_d};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alarm_q <= '0;
      for (int n = 0; n < sfr_pkg::NumChanRegs; n++) begin
        silence_q[n] <= '0;
      end
    end else begin
      alarm_q <= alarm_d;
      for (int n = 0; n < sfr_pkg::NumChanRegs; n++) begin
        silence_q[n] <= silence_d[n];
      end
    end
  end

  assign push = in_accept && (is_tick || frame.done);
  assign pop  = out_valid_o && !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      count_q <= count_q + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      buf_q[wr_ptr_q] <= result;
    end
  end

  assign out_valid_o             = (count_q != 2'd0);
  assign result_kind_o           = buf_q[rd_ptr_q].kind;
  assign matched_channel_o       = buf_q[rd_ptr_q].matched_channel;
  assign frame_sensor_id_o       = buf_q[rd_ptr_q].sensor_id;
  assign frame_status_o          = buf_q[rd_ptr_q].status;
  assign frame_number_o          = buf_q[rd_ptr_q].frame_number;
  assign battery_bits_o          = buf_q[rd_ptr_q].battery;
  assign oxygen_bits_o           = buf_q[rd_ptr_q].oxygen;
  assign carbon_monoxide_bits_o  = buf_q[rd_ptr_q].carbon_monoxide;
  assign hydrogen_sulfide_bits_o = buf_q[rd_ptr_q].hydrogen_sulfide;
  assign explosive_gas_bits_o    = buf_q[rd_ptr_q].explosive_gas;
  assign alarm_mask_o            = buf_q[rd_ptr_q].alarm_mask;
  assign timeout_mask_o          = buf_q[rd_ptr_q].timeout_mask;

endmodule
`default_nettype wire

// File: hdl/sfr_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sfr_checker
// Port-level checks of the sensor frame receiver's reports.
// ----------------------------------------------------------------------------
module sfr_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        out_valid_o,
  input wire logic        out_stall_i,
  input wire logic        result_kind_o,
  input wire logic [2:0]  matched_channel_o,
  input wire logic [7:0]  frame_sensor_id_o,
  input wire logic [7:0]  frame_status_o,
  input wire logic [23:0] frame_number_o,
  input wire logic [31:0] battery_bits_o,
  input wire logic [31:0] oxygen_bits_o,
  input wire logic [31:0] carbon_monoxide_bits_o,
  input wire logic [31:0] hydrogen_sulfide_bits_o,
  input wire logic [31:0] explosive_gas_bits_o,
  input wire logic [4:0]  alarm_mask_o,
  input wire logic [3:0]  timeout_mask_o
);

  logic [4:0] hit_alarm;
  assign hit_alarm = alarm_mask_o >> matched_channel_o;

  // a stalled beat keeps its report
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(result_kind_o) &&
      $stable(matched_channel_o) && $stable(timeout_mask_o) && $stable(alarm_mask_o))
    else $error("stalled report changed");

  // timeout reports carry nothing but flags
  a_tick_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (result_kind_o == sfr_pkg::KindTick) |->
      (matched_channel_o == 3'd0) && (frame_sensor_id_o == 8'd0) &&
      (frame_status_o == 8'd0) && (frame_number_o == 24'd0) &&
      (battery_bits_o == 32'd0) && (oxygen_bits_o == 32'd0) &&
      (carbon_monoxide_bits_o == 32'd0) && (hydrogen_sulfide_bits_o == 32'd0) &&
      (explosive_gas_bits_o == 32'd0) && (alarm_mask_o == 5'd0))
    else $error("timeout report carries frame fields");

  // frame reports: no flags, sane channel, summary alarm bit
  a_frame_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (result_kind_o == sfr_pkg::KindFrame) |->
      (timeout_mask_o == 4'd0) && (matched_channel_o <= sfr_pkg::NoChannel) &&
      (alarm_mask_o[4] == (|alarm_mask_o[3:0])))
    else $error("malformed frame report");

  // the matched channel's alarm follows this frame's status
  a_hit_alarm: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (result_kind_o == sfr_pkg::KindFrame) &&
      (matched_channel_o < sfr_pkg::NoChannel) |->
      hit_alarm[0] == (frame_status_o == 8'd1))
    else $error("matched channel alarm disagrees with status");

endmodule

bind sensor_frame_receiver sfr_checker u_sfr_checker (
  .clk_i                  (clk_i),
  .rst_ni                 (rst_ni),
  .out_valid_o            (out_valid_o),
  .out_stall_i            (out_stall_i),
  .result_kind_o          (result_kind_o),
  .matched_channel_o      (matched_channel_o),
  .frame_sensor_id_o      (frame_sensor_id_o),
  .frame_status_o         (frame_status_o),
  .frame_number_o         (frame_number_o),
  .battery_bits_o         (battery_bits_o),
  .oxygen_bits_o          (oxygen_bits_o),
  .carbon_monoxide_bits_o (carbon_monoxide_bits_o),
  .hydrogen_sulfide_bits_o(hydrogen_sulfide_bits_o),
  .explosive_gas_bits_o   (explosive_gas_bits_o),
  .alarm_mask_o           (alarm_mask_o),
  .timeout_mask_o         (timeout_mask_o)
);
`default_nettype wire

// File: tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the sensor frame receiver: byte and tick beats go
// in through valid/stall, frame and timeout reports are predicted in a
// scoreboard and compared field by field as they leave the block.
// ----------------------------------------------------------------------------
module tb_top;
  import sfr_pkg::*;

  localparam int WatchdogLimit = 3000;
  localparam int HoldOffCycles = 100;
  localparam int TailCycles    = 8;

  typedef enum int {FrameGood, BadMark, BadSum, BadEnd} flaw_e;

  // predicts reports from accepted beats and holds them until they arrive
  class report_scoreboard;
    typedef enum logic [2:0] {
      ParseHunt, ParseId, ParseMark, ParseLen, ParseData, ParseSum, ParseEnd
    } parse_e;

    logic [3:0]  chan_en;
    logic [15:0] chan_id [Channels];
    logic [15:0] quiet_limit;

    parse_e      phase;
    logic [7:0]  frame_id;
    logic [7:0]  frame_len;
    logic [7:0]  byte_cnt;
    logic [7:0]  byte_sum;
    logic [7:0]  store [PayloadBytes];
    logic [3:0]  alarm;
    logic [15:0] quiet [Channels];

    result_t     pending_reports [$];
    int          errors;

    function new();
      chan_en     = '0;
      quiet_limit = LimitReset;
      phase       = ParseHunt;
      frame_id    = '0;
      frame_len   = '0;
      byte_cnt    = '0;
      byte_sum    = '0;
      alarm       = '0;
      errors      = 0;
      foreach (chan_id[n]) chan_id[n] = '0;
      foreach (quiet[n]) quiet[n] = '0;
      foreach (store[k]) store[k] = '0;
    endfunction

    function void set_reg(cfg_reg_e idx, logic [15:0] val);
      case (idx)
        CfgChannelEnable: chan_en = val[3:0];
        CfgChannelId0:    chan_id[0] = val;
        CfgChannelId1:    chan_id[1] = val;
        CfgChannelId2:    chan_id[2] = val;
        CfgChannelId3:    chan_id[3] = val;
        CfgSilenceLimit:  quiet_limit = val;
        default: ;
      endcase
    endfunction

    // bytes past the declared length read as zero
    function logic [7:0] data_byte(int k);
      if (k < int'(frame_len) && k < int'(PayloadBytes)) return store[k];
      return 8'h00;
    endfunction

    function logic [31:0] le_word(int k);
      return {data_byte(k + 3), data_byte(k + 2), data_byte(k + 1), data_byte(k)};
    endfunction

    function void resync(logic [7:0] b);
      phase = (b == StartByte) ? ParseId : ParseHunt;
    endfunction

    function void close_frame();
      result_t     r;
      logic [2:0]  hit;
      logic [31:0] w;
      hit = NoChannel;
      for (int n = 0; n < Channels; n++) begin
        if (hit == NoChannel && chan_en[n] && chan_id[n] == {8'h00, frame_id}) hit = 3'(n);
      end
      if (hit != NoChannel) begin
        alarm[hit]  = (data_byte(0) == 8'd1);
        quiet[hit]  = '0;
      end
      r                  = '0;
      r.kind             = KindFrame;
      r.matched_channel  = hit;
      r.sensor_id        = frame_id;
      r.status           = data_byte(0);
      w                  = le_word(1);
      r.frame_number     = w[23:0];
      r.battery          = le_word(4);
      r.oxygen           = le_word(8);
      r.carbon_monoxide  = le_word(12);
      r.hydrogen_sulfide = le_word(16);
      r.explosive_gas    = le_word(20);
      r.alarm_mask       = {|alarm, alarm};
      pending_reports.push_back(r);
    endfunction

    function void take_beat(op_e op, logic [7:0] b);
      result_t r;
      if (op == OpTick) begin
        r      = '0;
        r.kind = KindTick;
        for (int n = 0; n < Channels; n++) begin
          if (quiet[n] != CountMax) quiet[n] = quiet[n] + 16'd1;
          if (quiet[n] >= quiet_limit) begin
            if (chan_en[n]) begin
              quiet[n]          = quiet_limit;
              r.timeout_mask[n] = 1'b1;
            end else begin
              quiet[n] = '0;
            end
          end
        end
        pending_reports.push_back(r);
        return;
      end
      case (phase)
        ParseId: begin
          frame_id = b;
          phase    = ParseMark;
        end
        ParseMark: begin
          if (b == MarkByte) phase = ParseLen;
          else resync(b);
        end
        ParseLen: begin
          frame_len = b;
          byte_cnt  = '0;
          byte_sum  = '0;
          phase     = (b == 8'h00) ? ParseSum : ParseData;
        end
        ParseData: begin
          if (byte_cnt < PayloadBytes) store[byte_cnt] = b;
          byte_sum = byte_sum + b;
          byte_cnt = byte_cnt + 8'd1;
          if (byte_cnt == frame_len) phase = ParseSum;
        end
        ParseSum: begin
          if (b == byte_sum) phase = ParseEnd;
          else resync(b);
        end
        ParseEnd: begin
          if (b == EndByte) begin
            phase = ParseHunt;
            close_frame();
          end else begin
            resync(b);
          end
        end
        default: resync(b);
      endcase
    endfunction

    task note(string msg);
      $display("tb_top: mismatch at %0t: %s", $time, msg);
      errors++;
    endtask

    task compare(string name, logic [31:0] got, logic [31:0] want);
      if (got !== want) note($sformatf("%s got %h want %h", name, got, want));
    endtask

    task check_report(result_t got);
      result_t want;
      if (pending_reports.size() == 0) begin
        note("report with nothing expected");
        return;
      end
      want = pending_reports.pop_front();
      compare("result_kind", 32'(got.kind), 32'(want.kind));
      compare("matched_channel", 32'(got.matched_channel), 32'(want.matched_channel));
      compare("frame_sensor_id", 32'(got.sensor_id), 32'(want.sensor_id));
      compare("frame_status", 32'(got.status), 32'(want.status));
      compare("frame_number", 32'(got.frame_number), 32'(want.frame_number));
      compare("battery_bits", got.battery, want.battery);
      compare("oxygen_bits", got.oxygen, want.oxygen);
      compare("carbon_monoxide_bits", got.carbon_monoxide, want.carbon_monoxide);
      compare("hydrogen_sulfide_bits", got.hydrogen_sulfide, want.hydrogen_sulfide);
      compare("explosive_gas_bits", got.explosive_gas, want.explosive_gas);
      compare("alarm_mask", 32'(got.alarm_mask), 32'(want.alarm_mask));
      compare("timeout_mask", 32'(got.timeout_mask), 32'(want.timeout_mask));
    endtask
  endclass

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        cfg_we_i    = 1'b0;
  logic [2:0]  cfg_index_i = CfgChannelEnable;
  logic [15:0] cfg_data_i  = '0;
  logic        in_valid_i  = 1'b0;
  logic        in_stall_o;
  logic        operation_i = OpByte;
  logic [7:0]  rx_byte_i   = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic        result_kind_o;
  logic [2:0]  matched_channel_o;
  logic [7:0]  frame_sensor_id_o;
  logic [7:0]  frame_status_o;
  logic [23:0] frame_number_o;
  logic [31:0] battery_bits_o;
  logic [31:0] oxygen_bits_o;
  logic [31:0] carbon_monoxide_bits_o;
  logic [31:0] hydrogen_sulfide_bits_o;
  logic [31:0] explosive_gas_bits_o;
  logic [4:0]  alarm_mask_o;
  logic [3:0]  timeout_mask_o;

  report_scoreboard sb;
  logic [15:0]      cur_ids [Channels];
  bit               in_idle_on  = 1'b1;
  bit               out_idle_on = 1'b1;
  bit               hold_req    = 1'b0;
  int               beats_sent  = 0;
  int               stuck_cycles = 0;

  sensor_frame_receiver dut (.*);

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // accepted beats feed the prediction before results of the same edge are checked
  always @(posedge clk_i) begin
    result_t got;
    if (rst_ni && sb != null) begin
      if (in_valid_i && !in_stall_o) sb.take_beat(op_e'(operation_i), rx_byte_i);
      if (out_valid_o && !out_stall_i) begin
        got.kind             = result_kind_o;
        got.matched_channel  = matched_channel_o;
        got.sensor_id        = frame_sensor_id_o;
        got.status           = frame_status_o;
        got.frame_number     = frame_number_o;
        got.battery          = battery_bits_o;
        got.oxygen           = oxygen_bits_o;
        got.carbon_monoxide  = carbon_monoxide_bits_o;
        got.hydrogen_sulfide = hydrogen_sulfide_bits_o;
        got.explosive_gas    = explosive_gas_bits_o;
        got.alarm_mask       = alarm_mask_o;
        got.timeout_mask     = timeout_mask_o;
        sb.check_report(got);
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || cfg_we_i || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      stuck_cycles = 0;
    end else begin
      stuck_cycles++;
      if (stuck_cycles >= WatchdogLimit) begin
        $display("tb_top: done, errors");
        $finish;
      end
    end
  end

  // receiver side: random stall bursts, plus one long hold-off on request
  initial begin
    int  dur;
    bit  lvl;
    @(posedge clk_i);
    forever begin
      if (hold_req) begin
        lvl      = 1'b1;
        dur      = HoldOffCycles;
        hold_req = 1'b0;
      end else if (out_idle_on && $urandom_range(0, 3) == 0) begin
        lvl = 1'b1;
        dur = $urandom_range(1, 19);
      end else begin
        lvl = 1'b0;
        dur = $urandom_range(1, 12);
      end
      out_stall_i <= lvl;
      repeat (dur) @(posedge clk_i);
    end
  end

  task automatic send_beat(op_e op, logic [7:0] b);
    int gap;
    if (in_idle_on && $urandom_range(0, 7) == 0) begin
      gap = $urandom_range(1, 19);
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    operation_i <= op;
    rx_byte_i   <= b;
    do @(posedge clk_i); while (in_stall_o);
    beats_sent++;
  endtask

  // one edge first so the last accepted beat is already predicted
  task automatic settle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.pending_reports.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic configure(logic [3:0] en, logic [15:0] id0, logic [15:0] id1,
                           logic [15:0] id2, logic [15:0] id3, logic [15:0] lim);
    cfg_reg_e    regs [6] = '{CfgChannelEnable, CfgChannelId0, CfgChannelId1,
                              CfgChannelId2, CfgChannelId3, CfgSilenceLimit};
    logic [15:0] vals [6];
    vals       = '{{12'h000, en}, id0, id1, id2, id3, lim};
    cur_ids[0] = id0;
    cur_ids[1] = id1;
    cur_ids[2] = id2;
    cur_ids[3] = id3;
    for (int k = 0; k < 6; k++) begin
      cfg_we_i    <= 1'b1;
      cfg_index_i <= regs[k];
      cfg_data_i  <= vals[k];
      @(posedge clk_i);
      sb.set_reg(regs[k], vals[k]);
    end
    cfg_we_i <= 1'b0;
  endtask

  // a wrong byte is often a start byte so the parser restarts on it
  function automatic logic [7:0] wrong_byte(logic [7:0] right);
    logic [7:0] v;
    if (right != StartByte && $urandom_range(0, 2) == 0) return StartByte;
    do v = 8'($urandom_range(0, 255)); while (v == right);
    return v;
  endfunction

  function automatic logic [15:0] random_id();
    logic [7:0] hi;
    hi = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(1, 255)) : 8'h00;
    return {hi, 8'($urandom_range(0, 255))};
  endfunction

  function automatic logic [7:0] pick_frame_id();
    logic [15:0] id;
    if ($urandom_range(0, 3) == 0) return 8'($urandom_range(0, 255));
    id = cur_ids[$urandom_range(0, Channels - 1)];
    return id[7:0];
  endfunction

  // mostly short frames, a few long ones to cover bytes past the store
  function automatic int pick_frame_len();
    int r;
    r = $urandom_range(0, 31);
    if (r < 2) return 0;
    if (r < 22) return $urandom_range(1, 24);
    if (r < 27) return 24;
    if (r < 31) return $urandom_range(25, 60);
    return $urandom_range(61, 255);
  endfunction

  function automatic logic [7:0] pick_status();
    case ($urandom_range(0, 2))
      0:       return 8'h00;
      1:       return 8'h01;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [7:0] noise_byte();
    case ($urandom_range(0, 3))
      0:       return StartByte;
      1:       return MarkByte;
      2:       return EndByte;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic send_frame(logic [7:0] id, int len, flaw_e flaw);
    logic [7:0] sum;
    logic [7:0] d;
    sum = 8'h00;
    send_beat(OpByte, StartByte);
    send_beat(OpByte, id);
    if (flaw == BadMark) begin
      send_beat(OpByte, wrong_byte(MarkByte));
      return;
    end
    send_beat(OpByte, MarkByte);
    send_beat(OpByte, 8'(len));
    for (int k = 0; k < len; k++) begin
      d   = (k == 0) ? pick_status() : 8'($urandom_range(0, 255));
      sum = sum + d;
      send_beat(OpByte, d);
      // ticks between data bytes must not disturb the parser
      if ($urandom_range(0, 39) == 0) send_beat(OpTick, 8'($urandom_range(0, 255)));
    end
    if (flaw == BadSum) begin
      send_beat(OpByte, wrong_byte(sum));
      return;
    end
    send_beat(OpByte, sum);
    send_beat(OpByte, (flaw == BadEnd) ? wrong_byte(EndByte) : EndByte);
  endtask

  task automatic run_mix(int beats);
    int    stop;
    int    pick;
    flaw_e fl;
    stop = beats_sent + beats;
    while (beats_sent < stop) begin
      pick = $urandom_range(0, 19);
      if (pick < 4) begin
        send_beat(OpTick, 8'($urandom_range(0, 255)));
      end else if (pick < 6) begin
        send_beat(OpByte, noise_byte());
      end else if (pick < 16) begin
        send_frame(pick_frame_id(), pick_frame_len(), FrameGood);
      end else begin
        case ($urandom_range(0, 2))
          0:       fl = BadMark;
          1:       fl = BadSum;
          default: fl = BadEnd;
        endcase
        send_frame(pick_frame_id(), pick_frame_len(), fl);
      end
    end
  endtask

  initial begin
    // zero-length frame, short frame with alarm status, restart on a bad mark
    logic [7:0] opening [22] = '{
      8'h68, 8'h00, 8'h80, 8'h00, 8'h00, 8'h16,
      8'h68, 8'h12, 8'h80, 8'h02, 8'h01, 8'hFF, 8'h00, 8'h16,
      8'h68, 8'h34, 8'h68, 8'hFF, 8'h80, 8'h00, 8'h00, 8'h16
    };
    sb = new();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    configure(4'hF, 16'h0012, 16'h0034, 16'h0000, 16'h00FF, 16'd2);
    send_beat(OpTick, 8'hFF);
    foreach (opening[k]) send_beat(OpByte, opening[k]);
    send_beat(OpTick, 8'h00);
    settle();

    configure(4'hF, 16'h0012, 16'h0034, 16'h0056, 16'h0078, 16'd3);
    run_mix(120);
    // long receiver hold-off while ticks keep coming
    in_idle_on = 1'b0;
    hold_req   = 1'b1;
    repeat (60) send_beat(OpTick, 8'($urandom_range(0, 255)));
    in_idle_on = 1'b1;
    run_mix(100);
    settle();

    // nothing enabled, widest limit: counters just climb
    configure(4'h0, 16'h0000, 16'hFFFF, 16'h00FF, 16'h0080, 16'hFFFF);
    run_mix(220);
    settle();

    // counters above a tiny limit, duplicate ids: first channel wins
    configure(4'hF, 16'h0000, 16'h0012, 16'h0012, 16'h01FF, 16'd1);
    run_mix(220);
    settle();

    configure(4'h5, random_id(), random_id(), random_id(), random_id(), 16'd0);
    run_mix(220);
    settle();

    configure(4'hA, random_id(), random_id(), random_id(), random_id(),
              16'($urandom_range(2, 8)));
    run_mix(220);
    settle();

    in_idle_on  = 1'b0;
    out_idle_on = 1'b0;
    configure(4'hF, random_id(), random_id(), random_id(), random_id(), 16'd4);
    run_mix(220);

    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.pending_reports.size() != 0) @(posedge clk_i);
    repeat (TailCycles) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule
